// ----- hdl/tcw_pkg.sv -----
package tcw_pkg;

    // command codes of the input item
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    // field widths of the item ports
    localparam int CHAR_W  = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CELL_W  = 2 * CHAR_W;

    // cell address width, enough for every cell the row and column fields can name (32 rows x 128 columns)
    localparam int A_MAX_W = 14;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    typedef logic [ROW_W-1:0]   t_row_o;
    typedef logic [COL_W-1:0]   t_col_o;
    typedef logic [A_MAX_W-1:0] t_addr;

    // classified item handed from the front to the back
    typedef struct packed {
        t_cmd              cmd;
        logic              newline;
        logic              in_range;
        t_addr             addr;
        logic [CHAR_W-1:0] character;
        logic [CHAR_W-1:0] attribute;
    } t_op;

endpackage

// ----- hdl/tcw_ram.sv -----
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1920
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tcw_front.sv -----
module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_hold,
    input  tcw_pkg::t_cmd                 i_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_character,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_cell_attribute,
    input  logic [tcw_pkg::ROW_W-1:0]     i_target_row,
    input  logic [tcw_pkg::COL_W-1:0]     i_target_column,
    output logic                          o_op_valid,
    input  logic                          i_op_ready,
    output tcw_pkg::t_op                  o_op
);

    localparam logic [31:0] ROWS_U = 32'(ROWS);
    localparam logic [31:0] COLS_U = 32'(COLUMNS);
    localparam tcw_pkg::t_addr COLS_A = tcw_pkg::A_MAX_W'(COLUMNS);

    tcw_pkg::t_op r_q [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         push_ok;
    logic         pop_ok;
    tcw_pkg::t_op op_in;

    // classify the incoming item
    always_comb begin
        op_in.cmd       = i_cmd;
        op_in.newline   = (i_character == tcw_pkg::NEWLINE_CODE);
        op_in.in_range  = (32'(i_target_row) < ROWS_U) && (32'(i_target_column) < COLS_U);
        op_in.addr      = tcw_pkg::A_MAX_W'(i_target_row) * COLS_A
                        + tcw_pkg::A_MAX_W'(i_target_column);
        op_in.character = i_character;
        op_in.attribute = i_cell_attribute;
    end

    assign full       = (r_count == 2'd2) || i_hold;
    assign push_ok    = push && !full;
    assign o_op_valid = (r_count != 2'd0);
    assign pop_ok     = o_op_valid && i_op_ready;
    assign o_op       = r_q[r_rd_ptr];

    // two-entry op queue storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= op_in;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 2'd1;
            end else if (!push_ok && pop_ok) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- hdl/tcw_back.sv -----
module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_op_valid,
    output logic                          o_op_ready,
    input  tcw_pkg::t_op                  i_op,
    output logic                          o_hold,
    output logic                          empty,
    input  logic                          pop,
    output logic [tcw_pkg::CHAR_W-1:0]    o_read_character,
    output logic [tcw_pkg::CHAR_W-1:0]    o_read_attribute,
    output tcw_pkg::t_row_o               o_cursor_row_out,
    output tcw_pkg::t_col_o               o_cursor_column_out,
    output logic                          o_scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = $clog2(CELLS + COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
    localparam logic [SW-1:0] COLS_S     = SW'(COLUMNS);
    localparam logic [SW-1:0] CELLS_S    = SW'(CELLS);
    localparam logic [SW-1:0] LAST_S     = SW'(CELLS - 1);
    localparam logic [SW-1:0] SCROLL_BEG = SW'(2 * COLUMNS);
    localparam logic [SW-1:0] SCROLL_END = SW'(CELLS + COLUMNS);
    localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
    localparam logic [RW-1:0] ROW_FIRST  = RW'(1);
    localparam logic [CW-1:0] COL_LAST   = CW'(COLUMNS - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_SCROLL = 5'b00100,
        S_CLEAR  = 5'b01000,
        S_INIT   = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    logic [SW-1:0]             r_s, n_s;
    logic [RW-1:0]             r_row, n_row;
    logic [CW-1:0]             r_col, n_col;
    logic                      r_wv, n_wv;
    logic [AW-1:0]             r_waddr, n_waddr;
    logic                      r_wzero, n_wzero;
    logic                      r_rd_in_range, n_rd_in_range;
    logic                      r_res_valid, n_res_valid;
    logic [tcw_pkg::CHAR_W-1:0] r_res_char, r_res_attr;
    tcw_pkg::t_row_o           r_res_row;
    tcw_pkg::t_col_o           r_res_col;
    logic                      r_res_scr;

    logic                      slot_free;
    logic                      take;
    logic                      res_set;
    logic [tcw_pkg::CHAR_W-1:0] res_char, res_attr;
    logic                      res_scr;
    logic [AW-1:0]             cur_addr;

    logic                      we, re;
    logic [AW-1:0]             waddr, raddr;
    logic [tcw_pkg::CELL_W-1:0] wdata, rdata;
    logic [SW-1:0]             dst_s;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign slot_free  = !r_res_valid || pop;
    assign o_op_ready = (r_state == S_IDLE) && slot_free;
    assign take       = o_op_ready && i_op_valid;
    assign o_hold     = (r_state == S_INIT);
    assign cur_addr   = AW'(r_row) * COLS_A + AW'(r_col);
    assign dst_s      = r_s - COLS_S;

    // sequencer: cursor, store sweeps and result
    always_comb begin
        n_state       = r_state;
        n_s           = r_s;
        n_row         = r_row;
        n_col         = r_col;
        n_wv          = 1'b0;
        n_waddr       = r_waddr;
        n_wzero       = r_wzero;
        n_rd_in_range = r_rd_in_range;
        res_set       = 1'b0;
        res_char      = '0;
        res_attr      = '0;
        res_scr       = 1'b0;
        we            = 1'b0;
        waddr         = r_waddr;
        wdata         = '0;
        re            = 1'b0;
        raddr         = i_op.addr[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_op.cmd)
                        tcw_pkg::CMD_PUT: begin
                            if (!i_op.newline) begin
                                we    = 1'b1;
                                waddr = cur_addr;
                                wdata = {i_op.attribute, i_op.character};
                            end
                            if (i_op.newline || r_col == COL_LAST) begin
                                n_col = '0;
                                if (r_row == ROW_LAST) begin
                                    n_s     = SCROLL_BEG;
                                    n_state = S_SCROLL;
                                end else begin
                                    n_row   = r_row + RW'(1);
                                    res_set = 1'b1;
                                end
                            end else begin
                                n_col   = r_col + CW'(1);
                                res_set = 1'b1;
                            end
                        end
                        tcw_pkg::CMD_WRITE: begin
                            we      = i_op.in_range;
                            waddr   = i_op.addr[AW-1:0];
                            wdata   = {i_op.attribute, i_op.character};
                            res_set = 1'b1;
                        end
                        tcw_pkg::CMD_READ: begin
                            re            = i_op.in_range;
                            n_rd_in_range = i_op.in_range;
                            n_state       = S_READ;
                        end
                        default: begin
                            n_s     = '0;
                            n_state = S_CLEAR;
                        end
                    endcase
                end
            end
            S_READ: begin
                res_set = 1'b1;
                if (r_rd_in_range) begin
                    res_char = rdata[tcw_pkg::CHAR_W-1:0];
                    res_attr = rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                end
                n_state = S_IDLE;
            end
            S_SCROLL: begin
                // read row r+1 while writing the word read in the previous cycle to row r
                we    = r_wv;
                waddr = r_waddr;
                wdata = r_wzero ? '0 : rdata;
                raddr = r_s[AW-1:0];
                if (r_s != SCROLL_END) begin
                    re      = (r_s < CELLS_S);
                    n_wv    = 1'b1;
                    n_waddr = dst_s[AW-1:0];
                    n_wzero = (r_s >= CELLS_S);
                    n_s     = r_s + SW'(1);
                end else begin
                    n_row   = ROW_LAST;
                    n_col   = '0;
                    res_set = 1'b1;
                    res_scr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CLEAR, S_INIT: begin
                // zero one cell per cycle
                we    = 1'b1;
                waddr = r_s[AW-1:0];
                n_s   = r_s + SW'(1);
                if (r_s == LAST_S) begin
                    n_row   = ROW_FIRST;
                    n_col   = '0;
                    res_set = (r_state == S_CLEAR);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (res_set) begin
            n_res_valid = 1'b1;
        end else if (pop) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_s         <= '0;
            r_row       <= ROW_FIRST;
            r_col       <= '0;
            r_wv        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_s         <= n_s;
            r_row       <= n_row;
            r_col       <= n_col;
            r_wv        <= n_wv;
            r_res_valid <= n_res_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_waddr       <= n_waddr;
        r_wzero       <= n_wzero;
        r_rd_in_range <= n_rd_in_range;
        if (res_set) begin
            r_res_char <= res_char;
            r_res_attr <= res_attr;
            r_res_row  <= tcw_pkg::t_row_o'(n_row);
            r_res_col  <= tcw_pkg::t_col_o'(n_col);
            r_res_scr  <= res_scr;
        end
    end

    assign empty               = !r_res_valid;
    assign o_read_character    = r_res_char;
    assign o_read_attribute    = r_res_attr;
    assign o_cursor_row_out    = r_res_row;
    assign o_cursor_column_out = r_res_col;
    assign o_scrolled          = r_res_scr;

endmodule

// ----- hdl/text_console_writer.sv -----
// Text console writer: a ROWS x COLUMNS screen store of {attribute, character} cells.
// Input queue side: drive the item fields with push; the item is taken on a clock
// edge where push is high and full is low. Result queue side: while empty is low
// the oldest result is on the o_ ports; pop on such an edge takes it.
// Every item gives exactly one result, in order.
// Put and newline (when no scroll follows) and direct write are handled in the back
// end's idle state, a read goes through the registered store read, and a scroll or a
// clear is paced by the single store write port walking one cell per cycle.
// Ordinary text runs at one item per cycle while results are popped as they
// appear.
// A two-entry queue between front and back keeps taking items while the back end
// works or while a result waits; full rises when that queue is full.
// A waiting result holds the back end, so a stalled receiver only fills the queue.
// After reset the store is zeroed by a sweep over all ROWS * COLUMNS cells, during which
// full stays high; the cursor then sits at row 1, column 0, and empty is high.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_command,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_character,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_cell_attribute,
    input  logic [tcw_pkg::ROW_W-1:0]     i_target_row,
    input  logic [tcw_pkg::COL_W-1:0]     i_target_column,
    output logic                          empty,
    input  logic                          pop,
    output logic [tcw_pkg::CHAR_W-1:0]    o_read_character,
    output logic [tcw_pkg::CHAR_W-1:0]    o_read_attribute,
    output logic [tcw_pkg::ROW_W-1:0]     o_cursor_row_out,
    output logic [tcw_pkg::COL_W-1:0]     o_cursor_column_out,
    output logic                          o_scrolled
);

    logic         op_valid;
    logic         op_ready;
    logic         hold;
    tcw_pkg::t_op op;

    // front: accept and classify items
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_hold           (hold),
        .i_cmd            (tcw_pkg::t_cmd'(i_command)),
        .i_character      (i_character),
        .i_cell_attribute (i_cell_attribute),
        .i_target_row     (i_target_row),
        .i_target_column  (i_target_column),
        .o_op_valid       (op_valid),
        .i_op_ready       (op_ready),
        .o_op             (op)
    );

    // back: cursor, screen store and results
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_op_valid          (op_valid),
        .o_op_ready          (op_ready),
        .i_op                (op),
        .o_hold              (hold),
        .empty               (empty),
        .pop                 (pop),
        .o_read_character    (o_read_character),
        .o_read_attribute    (o_read_attribute),
        .o_cursor_row_out    (o_cursor_row_out),
        .o_cursor_column_out (o_cursor_column_out),
        .o_scrolled          (o_scrolled)
    );

endmodule

// ----- dv/tcw_checker.sv -----
`timescale 1ns / 100ps

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  logic [1:0]                    i_command,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_character,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_cell_attribute,
    input  logic [tcw_pkg::ROW_W-1:0]     i_target_row,
    input  logic [tcw_pkg::COL_W-1:0]     i_target_column,
    input  logic                          i_empty,
    input  logic                          i_pop,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_read_character,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_read_attribute,
    input  logic [tcw_pkg::ROW_W-1:0]     i_cursor_row_out,
    input  logic [tcw_pkg::COL_W-1:0]     i_cursor_column_out,
    input  logic                          i_scrolled,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [tcw_pkg::CHAR_W-1:0] character;
        logic [tcw_pkg::CHAR_W-1:0] attribute;
        tcw_pkg::t_row_o            row;
        tcw_pkg::t_col_o            column;
        logic                       scrolled;
    } t_console_result;

    // shadow copy of the console state
    logic [tcw_pkg::CELL_W-1:0] screen [ROWS*COLUMNS];
    int                cursor_row;
    int                cursor_column;

    t_console_result   expected_results[$];
    int                result_count = 0;
    int                fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] result %0d: %s is %0h, expected %0h",
                 $time, result_count, what, got, want);
        fail_count++;
    endtask

    // blank store, cursor to the first text row
    task automatic clear_screen();
        for (int idx = 0; idx < ROWS * COLUMNS; idx++) begin
            screen[idx] = '0;
        end
        cursor_row    = 1;
        cursor_column = 0;
    endtask

    always @(posedge i_clk) begin : watch
        t_console_result got;
        t_console_result want;
        t_console_result next_result;
        logic            in_range;
        int              addr;

        if (!i_rst_n) begin
            clear_screen();
            expected_results.delete();
        end else begin
            // compare the accepted result with the oldest prediction
            if (i_pop && !i_empty) begin
                got.character = i_read_character;
                got.attribute = i_read_attribute;
                got.row       = i_cursor_row_out;
                got.column    = i_cursor_column_out;
                got.scrolled  = i_scrolled;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none expected", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.character != want.character)
                        report_mismatch("read_character", 32'(got.character),
                                        32'(want.character));
                    if (got.attribute != want.attribute)
                        report_mismatch("read_attribute", 32'(got.attribute),
                                        32'(want.attribute));
                    if (got.row != want.row)
                        report_mismatch("cursor_row_out", 32'(got.row), 32'(want.row));
                    if (got.column != want.column)
                        report_mismatch("cursor_column_out", 32'(got.column),
                                        32'(want.column));
                    if (got.scrolled != want.scrolled)
                        report_mismatch("scrolled", 32'(got.scrolled), 32'(want.scrolled));
                end
                result_count++;
            end

            // predict the result of the accepted item
            if (i_push && !i_full) begin
                next_result = '0;
                in_range = (int'(i_target_row) < ROWS) && (int'(i_target_column) < COLUMNS);
                addr = int'(i_target_row) * COLUMNS + int'(i_target_column);
                case (tcw_pkg::t_cmd'(i_command))
                    tcw_pkg::CMD_PUT: begin
                        if (i_character != tcw_pkg::NEWLINE_CODE) begin
                            screen[cursor_row * COLUMNS + cursor_column] =
                                {i_cell_attribute, i_character};
                            cursor_column++;
                        end
                        // newline or wrap past the last column
                        if (i_character == tcw_pkg::NEWLINE_CODE ||
                            cursor_column >= COLUMNS) begin
                            cursor_column = 0;
                            cursor_row++;
                            if (cursor_row >= ROWS) begin
                                // text rows move up, status row stays, bottom row blanks
                                for (int idx = COLUMNS; idx < (ROWS - 1) * COLUMNS; idx++) begin
                                    screen[idx] = screen[idx + COLUMNS];
                                end
                                for (int idx = (ROWS - 1) * COLUMNS; idx < ROWS * COLUMNS;
                                     idx++) begin
                                    screen[idx] = '0;
                                end
                                cursor_row = ROWS - 1;
                                next_result.scrolled = 1'b1;
                            end
                        end
                    end
                    tcw_pkg::CMD_WRITE: begin
                        if (in_range) begin
                            screen[addr] = {i_cell_attribute, i_character};
                        end
                    end
                    tcw_pkg::CMD_READ: begin
                        if (in_range) begin
                            next_result.character = screen[addr][tcw_pkg::CHAR_W-1:0];
                            next_result.attribute =
                                screen[addr][tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                        end
                    end
                    default: begin
                        clear_screen();
                    end
                endcase
                next_result.row    = tcw_pkg::t_row_o'(cursor_row);
                next_result.column = tcw_pkg::t_col_o'(cursor_column);
                expected_results.push_back(next_result);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int          COLUMNS      = 80;
    localparam int          ROWS         = 24;
    localparam int          PHASE_ITEMS  = 425;
    localparam int          DRAIN_CYCLES = 64;
    // every item a full-store walk plus long gaps and stalls, taken several times
    localparam int unsigned CYCLE_LIMIT  = 16_000_000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic [1:0]                 i_command = tcw_pkg::CMD_PUT;
    logic [tcw_pkg::CHAR_W-1:0] i_character = '0;
    logic [tcw_pkg::CHAR_W-1:0] i_cell_attribute = '0;
    tcw_pkg::t_row_o            i_target_row = '0;
    tcw_pkg::t_col_o            i_target_column = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [tcw_pkg::CHAR_W-1:0] o_read_character;
    logic [tcw_pkg::CHAR_W-1:0] o_read_attribute;
    tcw_pkg::t_row_o            o_cursor_row_out;
    tcw_pkg::t_col_o            o_cursor_column_out;
    logic                       o_scrolled;

    int                 fail_count;
    int                 pending;
    int                 items_sent = 0;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int unsigned        cycle_count = 0;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_command           (i_command),
        .i_character         (i_character),
        .i_cell_attribute    (i_cell_attribute),
        .i_target_row        (i_target_row),
        .i_target_column     (i_target_column),
        .empty               (empty),
        .pop                 (pop),
        .o_read_character    (o_read_character),
        .o_read_attribute    (o_read_attribute),
        .o_cursor_row_out    (o_cursor_row_out),
        .o_cursor_column_out (o_cursor_column_out),
        .o_scrolled          (o_scrolled)
    );

    tcw_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) console_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .i_full              (full),
        .i_command           (i_command),
        .i_character         (i_character),
        .i_cell_attribute    (i_cell_attribute),
        .i_target_row        (i_target_row),
        .i_target_column     (i_target_column),
        .i_empty             (empty),
        .i_pop               (pop),
        .i_read_character    (o_read_character),
        .i_read_attribute    (o_read_attribute),
        .i_cursor_row_out    (o_cursor_row_out),
        .i_cursor_column_out (o_cursor_column_out),
        .i_scrolled          (o_scrolled),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_console_writer test failed");
            $finish;
        end
    end

    // result side stalls
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= stall_pct);
    end

    // present one item, hold it until taken
    task automatic send_item(input tcw_pkg::t_cmd cmd,
                             input logic [tcw_pkg::CHAR_W-1:0] ch,
                             input logic [tcw_pkg::CHAR_W-1:0] attr,
                             input tcw_pkg::t_row_o row,
                             input tcw_pkg::t_col_o col);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        push             <= 1'b1;
        i_command        <= cmd;
        i_character      <= ch;
        i_cell_attribute <= attr;
        i_target_row     <= row;
        i_target_column  <= col;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    // hold off the sender until every result is back
    task automatic wait_for_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int target;
        int choice;
        int count;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, status line, out of range, clear
        send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_PUT, 8'h41, 8'hFF, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_PUT, 8'h00, 8'h00, 5'd31, 7'd127);
        send_item(tcw_pkg::CMD_PUT, 8'hFF, 8'h80, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, 8'h5A, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_WRITE, 8'h55, 8'hAA, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_WRITE, 8'hFF, 8'hFF, 5'(ROWS - 1), 7'(COLUMNS - 1));
        send_item(tcw_pkg::CMD_WRITE, 8'h12, 8'h34, 5'(ROWS), 7'd3);
        send_item(tcw_pkg::CMD_WRITE, 8'h12, 8'h34, 5'd31, 7'd127);
        send_item(tcw_pkg::CMD_WRITE, 8'h12, 8'h34, 5'd2, 7'(COLUMNS));
        send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1));
        send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 5'd1, 7'd1);
        send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 5'd1, 7'd2);
        send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 5'(ROWS), 7'd5);
        send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 5'd3, 7'(COLUMNS));
        send_item(tcw_pkg::CMD_READ, 8'hFF, 8'hFF, 5'd31, 7'd127);
        send_item(tcw_pkg::CMD_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0);
        send_item(tcw_pkg::CMD_READ, 8'h00, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1));

        // random: mostly text lines, wraps, cell writes and read-back, rare clears, some noise
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 51;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 51;
                end
                default: begin
                    idle_pct  = 26;
                    stall_pct = 26;
                end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                choice = $urandom_range(99);
                if (choice < 45) begin
                    // short text line ended by newline
                    count = $urandom_range(30);
                    repeat (count) begin
                        send_item(tcw_pkg::CMD_PUT, 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 5'($urandom_range(31)),
                                  7'($urandom_range(127)));
                    end
                    send_item(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE,
                              8'($urandom_range(255)), 5'($urandom_range(31)),
                              7'($urandom_range(127)));
                end else if (choice < 53) begin
                    // run long enough to wrap
                    count = $urandom_range(COLUMNS, COLUMNS + 20);
                    repeat (count) begin
                        send_item(tcw_pkg::CMD_PUT, 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 5'($urandom_range(31)),
                                  7'($urandom_range(127)));
                    end
                end else if (choice < 66) begin
                    // direct cell writes, status row included
                    count = $urandom_range(1, 4);
                    repeat (count) begin
                        send_item(tcw_pkg::CMD_WRITE, 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 5'($urandom_range(ROWS - 1)),
                                  7'($urandom_range(COLUMNS - 1)));
                    end
                end else if (choice < 87) begin
                    // read back cells
                    count = $urandom_range(1, 6);
                    repeat (count) begin
                        send_item(tcw_pkg::CMD_READ, 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 5'($urandom_range(ROWS - 1)),
                                  7'($urandom_range(COLUMNS - 1)));
                    end
                end else if (choice < 88) begin
                    send_item(tcw_pkg::CMD_CLEAR, 8'($urandom_range(255)),
                              8'($urandom_range(255)), 5'($urandom_range(31)),
                              7'($urandom_range(127)));
                end else begin
                    // noise over the full field ranges
                    count = $urandom_range(1, 3);
                    repeat (count) begin
                        send_item(tcw_pkg::t_cmd'($urandom_range(3)),
                                  8'($urandom_range(255)), 8'($urandom_range(255)),
                                  5'($urandom_range(31)), 7'($urandom_range(127)));
                    end
                end
            end
            wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("text_console_writer test passed");
        end else begin
            $display("text_console_writer test failed");
        end
        $finish;
    end

endmodule
